// ===== hw/rtl/digit_driven_permutation_shuffle_core_defines.svh =====
// assertion macros shared by the shuffle core checkers
`ifndef DIGIT_DRIVEN_PERMUTATION_SHUFFLE_CORE_DEFINES_SVH
`define DIGIT_DRIVEN_PERMUTATION_SHUFFLE_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define DDPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shuffle core check failed");

// next-cycle implication, off during reset
`define DDPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shuffle core check failed");

`endif

// ===== hw/rtl/ddps_pkg.sv =====
// types and constants of the digit-driven shuffle core
package ddps_pkg;

  // width of the digit group value, the bound and the group range
  localparam int ACC_W = 10;

  // command codes
  localparam logic CMD_DIGIT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // result event codes
  localparam logic [1:0] EV_PARTIAL = 2'd0;
  localparam logic [1:0] EV_SWAP    = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;
  localparam logic [1:0] EV_NONE    = 2'd3;

  // largest decimal digit
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // bound thresholds for the group length
  localparam logic [ACC_W-1:0] BOUND_ONE = 10'd10;
  localparam logic [ACC_W-1:0] BOUND_TWO = 10'd100;

  // group ranges for one, two and three digits
  localparam logic [ACC_W-1:0] RANGE_ONE   = 10'd10;
  localparam logic [ACC_W-1:0] RANGE_TWO   = 10'd100;
  localparam logic [ACC_W-1:0] RANGE_THREE = 10'd1000;

  // group lengths
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [3:0] digit;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] entry_value;
    logic [1:0] event_res;
    logic       finished;
  } out_item_t;

  // divider results toward the control
  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quo_a;
    logic [ACC_W-1:0] rem_a;
    logic [ACC_W-1:0] quo_b;
  } div_res_t;

endpackage

// ===== hw/rtl/ddps_div.sv =====
// two-lane restoring divider sharing one divisor, one quotient bit per cycle
module ddps_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ddps_pkg::ACC_W-1:0] divisor,
  input  logic [ddps_pkg::ACC_W-1:0] dividend_a,
  input  logic [ddps_pkg::ACC_W-1:0] dividend_b,
  output ddps_pkg::div_res_t      res
);
  import ddps_pkg::*;

  localparam int CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] dvs_r, dvs_nxt;
  logic [ACC_W-1:0] qa_r, qa_nxt, ra_r, ra_nxt;
  logic [ACC_W-1:0] qb_r, qb_nxt, rb_r, rb_nxt;
  logic [2*ACC_W-1:0] step_a, step_b;

  // one restoring step: returns {remainder, quotient}
  function automatic logic [2*ACC_W-1:0] div_step(input logic [ACC_W-1:0] rem,
                                                  input logic [ACC_W-1:0] quo,
                                                  input logic [ACC_W-1:0] dvs);
    logic [ACC_W:0] r_sh;
    logic [ACC_W:0] r_sub;
    r_sh  = {rem, quo[ACC_W-1]};
    r_sub = r_sh - {1'b0, dvs};
    if (r_sh >= {1'b0, dvs}) begin
      div_step = {r_sub[ACC_W-1:0], quo[ACC_W-2:0], 1'b1};
    end else begin
      div_step = {r_sh[ACC_W-1:0], quo[ACC_W-2:0], 1'b0};
    end
  endfunction

  assign step_a = div_step(ra_r, qa_r, dvs_r);
  assign step_b = div_step(rb_r, qb_r, dvs_r);

  // iteration control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvs_nxt  = dvs_r;
    qa_nxt   = qa_r;
    ra_nxt   = ra_r;
    qb_nxt   = qb_r;
    rb_nxt   = rb_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvs_nxt  = divisor;
      qa_nxt   = dividend_a;
      ra_nxt   = '0;
      qb_nxt   = dividend_b;
      rb_nxt   = '0;
    end else if (busy_r) begin
      {ra_nxt, qa_nxt} = step_a;
      {rb_nxt, qb_nxt} = step_b;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvs_r <= dvs_nxt;
    qa_r  <= qa_nxt;
    ra_r  <= ra_nxt;
    qb_r  <= qb_nxt;
    rb_r  <= rb_nxt;
  end

  assign res.done  = done_r;
  assign res.quo_a = qa_r;
  assign res.rem_a = ra_r;
  assign res.quo_b = qb_r;

endmodule

// ===== hw/rtl/ddps_table.sv =====
// permutation table memory, one write port and one registered read port
module ddps_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int EW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [EW-1:0] rd_data
);

  logic [EW-1:0] mem_r [DEPTH];
  logic [EW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/digit_driven_permutation_shuffle_core.sv =====
// Digit-driven Fisher-Yates shuffle core: the permutation table lives in one
// synchronous memory (one write, one read port) and is filled with the
// identity by a clearing pass over every entry after reset, during which
// in_stall stays high. One item is worked at a time. A read, an ignored
// digit and a digit that leaves a group partial go straight to the output
// stage. A full group runs through the restoring divider, which gives the
// remainder mod n and the acceptance test together; a rejected group ends
// there, while for an accepted group the swap takes two reads and two writes
// on the single memory port pair. A finished item may wait in the output
// register while the next item is taken.
module digit_driven_permutation_shuffle_core #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ddps_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ddps_pkg::out_item_t out_item
);
  import ddps_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int EW = AW;
  localparam int PW = $clog2(TABLE_SIZE + 1);
  localparam logic [PW-1:0] POS_END  = PW'(TABLE_SIZE);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_SIZE - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RDP  = 3'd3;
  localparam logic [2:0] ST_WRJ  = 3'd4;
  localparam logic [2:0] ST_WRP  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [1:0]       taken_r, taken_nxt;
  logic [AW-1:0]    j_r, j_nxt;
  logic [EW-1:0]    tmp_r, tmp_nxt;
  logic [1:0]       ev_r, ev_nxt;
  logic             sel_mem_r, sel_mem_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [EW-1:0]    wr_data, rd_data;
  logic             div_start;
  div_res_t         div_res;
  logic [AW-1:0]    div_j;

  logic [ACC_W-1:0] bound_n;
  logic [1:0]       grp_len;
  logic [ACC_W-1:0] grp_range;
  logic [ACC_W-1:0] acc_new;
  logic [1:0]       taken_new;
  logic             rd_ok;
  logic             out_load;

  // group shape from the bound n = position + 1
  always_comb begin
    bound_n = ACC_W'(pos_r) + ACC_W'(1);
    if (bound_n > BOUND_TWO) begin
      grp_len   = LEN_THREE;
      grp_range = RANGE_THREE;
    end else if (bound_n > BOUND_ONE) begin
      grp_len   = LEN_TWO;
      grp_range = RANGE_TWO;
    end else begin
      grp_len   = LEN_ONE;
      grp_range = RANGE_ONE;
    end
  end

  // accumulator times ten plus the new digit
  assign acc_new   = ACC_W'({acc_r, 3'b000}) + ACC_W'({acc_r, 1'b0}) + ACC_W'(in_item.digit);
  assign taken_new = taken_r + 2'd1;
  assign rd_ok     = int'(in_item.read_index) < TABLE_SIZE;
  assign div_j     = AW'(div_res.rem_a);

  ddps_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .divisor    (bound_n),
    .dividend_a (acc_new),
    .dividend_b (grp_range),
    .res        (div_res)
  );

  ddps_table #(
    .DEPTH (TABLE_SIZE),
    .AW    (AW),
    .EW    (EW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: clear, take item, divide, swap, deliver
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    taken_nxt   = taken_r;
    j_nxt       = j_r;
    tmp_nxt     = tmp_r;
    ev_nxt      = ev_r;
    sel_mem_nxt = sel_mem_r;
    rd_en       = 1'b0;
    rd_addr     = j_r;
    wr_en       = 1'b0;
    wr_addr     = j_r;
    wr_data     = tmp_r;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = EW'(clr_r);
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          ev_nxt      = EV_NONE;
          sel_mem_nxt = 1'b0;
          state_nxt   = ST_DONE;
          if (in_item.cmd == CMD_READ) begin
            if (rd_ok) begin
              rd_en       = 1'b1;
              rd_addr     = AW'(in_item.read_index);
              sel_mem_nxt = 1'b1;
            end
          end else if (pos_r < POS_END && in_item.digit <= DIGIT_MAX) begin
            if (taken_new < grp_len) begin
              acc_nxt   = acc_new;
              taken_nxt = taken_new;
              ev_nxt    = EV_PARTIAL;
            end else begin
              acc_nxt   = '0;
              taken_nxt = '0;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_res.quo_a < div_res.quo_b) begin
            j_nxt     = div_j;
            rd_en     = 1'b1;
            rd_addr   = div_j;
            state_nxt = ST_RDP;
          end else begin
            ev_nxt    = EV_REJECT;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RDP: begin
        tmp_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = AW'(pos_r);
        state_nxt = ST_WRJ;
      end
      ST_WRJ: begin
        wr_en     = 1'b1;
        wr_addr   = j_r;
        wr_data   = rd_data;
        state_nxt = ST_WRP;
      end
      ST_WRP: begin
        wr_en     = 1'b1;
        wr_addr   = AW'(pos_r);
        wr_data   = tmp_r;
        pos_nxt   = pos_r + PW'(1);
        ev_nxt    = EV_SWAP;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.entry_value = sel_mem_r ? 8'(rd_data) : 8'd0;
      out_item_nxt.event_res   = ev_r;
      out_item_nxt.finished    = pos_r >= POS_END;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      pos_r       <= PW'(1);
      acc_r       <= '0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    tmp_r      <= tmp_nxt;
    ev_r       <= ev_nxt;
    sel_mem_r  <= sel_mem_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/ddps_checker.sv =====
// port-level checker for the shuffle core and its bind
`include "digit_driven_permutation_shuffle_core_defines.svh"

module ddps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ddps_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input ddps_pkg::out_item_t out_item
);
  import ddps_pkg::*;

  logic fin_seen_r, fin_seen_nxt;

  // remember that a finished item has been delivered
  assign fin_seen_nxt = fin_seen_r || (out_valid && !out_stall && out_item.finished);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_seen_r <= 1'b0;
    end else begin
      fin_seen_r <= fin_seen_nxt;
    end
  end

  // a stalled item holds
  `DDPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // one item in work at a time
  `DDPS_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // only reads carry a table value
  `DDPS_ASSERT_NOW(a_value_on_read, out_valid && out_item.event_res != EV_NONE,
                   out_item.entry_value == 8'd0)

  // once finished, stays finished and no group work follows
  `DDPS_ASSERT_NOW(a_finish_sticky, out_valid && fin_seen_r,
                   out_item.finished && out_item.event_res == EV_NONE)

endmodule

bind digit_driven_permutation_shuffle_core ddps_checker u_ddps_checker (.*);

// ===== test/digit_driven_permutation_shuffle_core_tb.sv =====
// self-checking testbench for the digit-driven permutation shuffle core
`timescale 1ns / 100ps

module digit_driven_permutation_shuffle_core_tb;
  import ddps_pkg::*;

  localparam int TABLE_SIZE     = 256;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int DEC_BASE       = 10;
  localparam int IDLE_PCT       = 23;
  localparam int CALM_LO        = 400;
  localparam int CALM_HI        = 600;
  localparam int HOLDOFF_AT     = 200;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 40;

  // one queued item, optionally held back until all results are in
  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pending_item_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  pending_item_t stim_q[$];
  out_item_t     expected_results[$];
  int            items_sent   = 0;
  int            results_seen = 0;
  int            mismatches   = 0;
  int            holdoff_left = 0;
  bit            holdoff_done = 1'b0;

  // shadow copy of the shuffle state
  logic [7:0]  shadow_perm [TABLE_SIZE];
  int unsigned shadow_pos;
  int unsigned shadow_acc;
  int unsigned shadow_taken;

  digit_driven_permutation_shuffle_core #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("digit_driven_permutation_shuffle_core verification failed");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic void queue_item(logic cmd, logic [3:0] digit, logic [7:0] idx,
                                     bit drain);
    pending_item_t p;
    p.item.cmd        = cmd;
    p.item.digit      = digit;
    p.item.read_index = idx;
    p.drain_first     = drain;
    stim_q.push_back(p);
  endfunction

  // advance the shadow shuffle by one item and give the result it produces
  function automatic out_item_t predict_shuffle(in_item_t it);
    out_item_t   res;
    int unsigned n;
    logic [1:0]  len;
    int unsigned span;
    int unsigned limit;
    int unsigned j;
    logic [7:0]  tmp;
    res = '0;
    res.event_res = EV_NONE;
    if (it.cmd == CMD_READ) begin
      if (it.read_index < TABLE_SIZE) res.entry_value = shadow_perm[it.read_index];
    end else if (shadow_pos < TABLE_SIZE && it.digit <= DIGIT_MAX) begin
      n = shadow_pos + 1;
      len = (n > BOUND_TWO) ? LEN_THREE : (n > BOUND_ONE) ? LEN_TWO : LEN_ONE;
      span = 32'((len == LEN_THREE) ? RANGE_THREE :
                 (len == LEN_TWO) ? RANGE_TWO : RANGE_ONE);
      shadow_acc = shadow_acc * DEC_BASE + it.digit;
      shadow_taken++;
      if (shadow_taken < len) begin
        res.event_res = EV_PARTIAL;
      end else begin
        // full group: accept below the largest multiple of n, else throw away
        limit = n * (span / n);
        if (shadow_acc < limit) begin
          j = shadow_acc % n;
          tmp = shadow_perm[j];
          shadow_perm[j] = shadow_perm[shadow_pos];
          shadow_perm[shadow_pos] = tmp;
          shadow_pos++;
          res.event_res = EV_SWAP;
        end else begin
          res.event_res = EV_REJECT;
        end
        shadow_acc = 0;
        shadow_taken = 0;
      end
    end
    res.finished = (shadow_pos >= TABLE_SIZE);
    return res;
  endfunction

  // input driver: record accepted item, then offer the next one or idle
  always @(posedge clk) begin
    pending_item_t nxt_p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_shuffle(in_item));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (stim_q.size() == 0 ||
            (stim_q[0].drain_first && expected_results.size() != 0) ||
            ((items_sent < CALM_LO || items_sent >= CALM_HI) &&
             $urandom_range(99) < IDLE_PCT)) begin
          in_valid <= 1'b0;
        end else begin
          nxt_p = stim_q.pop_front();
          in_valid <= 1'b1;
          in_item <= nxt_p.item;
        end
      end
    end
  end

  // result monitor: check against the oldest expectation, then pick stall
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item, event", out_item.event_res, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.entry_value !== want.entry_value)
            report_mismatch("entry_value", out_item.entry_value, want.entry_value);
          if (out_item.event_res !== want.event_res)
            report_mismatch("event_res", out_item.event_res, want.event_res);
          if (out_item.finished !== want.finished)
            report_mismatch("finished", out_item.finished, want.finished);
        end
        results_seen++;
      end
      // one long hold-off so the core backs up into its input
      if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= CALM_LO && results_seen < CALM_HI) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned r;
    logic [3:0]  dg;
    for (int k = 0; k < TABLE_SIZE; k++) shadow_perm[k] = k[7:0];
    shadow_pos = 1;
    shadow_acc = 0;
    shadow_taken = 0;

    // reads of the identity table with all index bits toggled
    queue_item(CMD_READ, 4'd0, 8'd0, 1'b0);
    queue_item(CMD_READ, 4'd15, 8'd255, 1'b0);
    queue_item(CMD_READ, 4'd5, 8'd170, 1'b0);
    queue_item(CMD_READ, 4'd10, 8'd85, 1'b0);
    // digits above nine are ignored
    queue_item(CMD_DIGIT, 4'd15, 8'd255, 1'b0);
    queue_item(CMD_DIGIT, 4'd10, 8'd0, 1'b0);
    // first swap, then a rejected single digit at bound three
    queue_item(CMD_DIGIT, 4'd0, 8'd0, 1'b0);
    queue_item(CMD_DIGIT, 4'd9, 8'd0, 1'b0);
    queue_item(CMD_DIGIT, 4'd12, 8'd0, 1'b0);
    queue_item(CMD_DIGIT, 4'd8, 8'd0, 1'b0);
    queue_item(CMD_DIGIT, 4'd7, 8'd255, 1'b0);
    queue_item(CMD_DIGIT, 4'd9, 8'd0, 1'b0);
    // look at the swapped entries
    queue_item(CMD_READ, 4'd0, 8'd0, 1'b0);
    queue_item(CMD_READ, 4'd0, 8'd1, 1'b0);
    queue_item(CMD_READ, 4'd0, 8'd2, 1'b0);
    queue_item(CMD_READ, 4'd0, 8'd4, 1'b0);

    // mostly good digits so the shuffle runs to its end, then ignored digits
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 86) begin
        dg = 4'($urandom_range(9));
        queue_item(CMD_DIGIT, dg, 8'($urandom_range(255)), i == 0 || i == 700);
      end else if (r < 91) begin
        dg = 4'($urandom_range(15, 10));
        queue_item(CMD_DIGIT, dg, 8'($urandom_range(255)), i == 0 || i == 700);
      end else begin
        queue_item(CMD_READ, 4'($urandom_range(15)), 8'($urandom_range(255)),
                   i == 0 || i == 700);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("digit_driven_permutation_shuffle_core verification clean");
    end else begin
      $display("digit_driven_permutation_shuffle_core verification failed");
    end
    $finish;
  end

endmodule
